// ----- rtl/core/qsed_pkg.sv -----
// Shared types, constants and helpers for the quoted string escape decoder.
package qsed_pkg;

    typedef enum logic [2:0] {
        PH_AWAIT,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_HEX2,
        PH_OCT,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_DONE,
        KIND_ERR
    } t_kind;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_dec_res;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'h0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            h.val = b[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- rtl/core/qsed_decode.sv -----
// Phase register and per-byte decode logic producing up to two results.
module qsed_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output qsed_pkg::t_dec_res o_res
);

    typedef struct packed {
        logic             emit;
        qsed_pkg::t_kind  kind;
        logic [7:0]       data;
        qsed_pkg::t_phase phase;
    } t_body;

    function automatic t_body body_step(logic [7:0] b);
        t_body r;
        r.emit  = 1'b1;
        r.kind  = qsed_pkg::KIND_BYTE;
        r.data  = b;
        r.phase = qsed_pkg::PH_BODY;
        if (b == qsed_pkg::CH_QUOTE) begin
            r.kind  = qsed_pkg::KIND_DONE;
            r.data  = 8'h00;
            r.phase = qsed_pkg::PH_DONE;
        end else if (b == qsed_pkg::CH_BSL) begin
            r.emit  = 1'b0;
            r.phase = qsed_pkg::PH_ESC;
        end
        return r;
    endfunction

    qsed_pkg::t_phase  r_phase, n_phase;
    logic [7:0]        r_pend, n_pend;
    t_body             bs;
    qsed_pkg::t_hex    hx;
    logic              pre_emit;
    logic [7:0]        pre_data;
    qsed_pkg::t_kind   pre_kind;
    logic              use_body;
    qsed_pkg::t_dec_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= qsed_pkg::PH_AWAIT;
            r_pend  <= 8'h00;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        bs       = body_step(i_byte);
        hx       = qsed_pkg::hex_value(i_byte);
        pre_emit = 1'b0;
        pre_data = 8'h00;
        pre_kind = qsed_pkg::KIND_BYTE;
        use_body = 1'b0;
        n_phase  = r_phase;
        n_pend   = r_pend;
        unique case (r_phase)
            qsed_pkg::PH_AWAIT: begin
                if (i_byte == qsed_pkg::CH_QUOTE) begin
                    n_phase = qsed_pkg::PH_BODY;
                end else begin
                    pre_emit = 1'b1;
                    pre_kind = qsed_pkg::KIND_ERR;
                    n_phase  = qsed_pkg::PH_DONE;
                end
            end
            qsed_pkg::PH_BODY: begin
                use_body = 1'b1;
            end
            qsed_pkg::PH_ESC: begin
                n_phase = qsed_pkg::PH_BODY;
                unique case (i_byte) inside
                    8'h6E, 8'h4E: begin
                        pre_emit = 1'b1;
                        pre_data = 8'h0A;
                    end
                    8'h74, 8'h54: begin
                        pre_emit = 1'b1;
                        pre_data = 8'h09;
                    end
                    8'h72, 8'h52: begin
                        pre_emit = 1'b1;
                        pre_data = 8'h0D;
                    end
                    8'h61, 8'h41: begin
                        pre_emit = 1'b1;
                        pre_data = 8'h07;
                    end
                    8'h62, 8'h42: begin
                        pre_emit = 1'b1;
                        pre_data = 8'h08;
                    end
                    8'h66, 8'h46: begin
                        pre_emit = 1'b1;
                        pre_data = 8'h0C;
                    end
                    8'h76, 8'h56: begin
                        pre_emit = 1'b1;
                        pre_data = 8'h0B;
                    end
                    8'h78, 8'h58: begin
                        n_phase = qsed_pkg::PH_HEX1;
                    end
                    [8'h31:8'h37]: begin
                        n_pend  = i_byte - qsed_pkg::CH_ZERO;
                        n_phase = qsed_pkg::PH_OCT;
                    end
                    8'h30: begin
                        pre_emit = 1'b1;
                        pre_data = 8'h00;
                    end
                    default: begin
                        pre_emit = 1'b1;
                        pre_data = i_byte;
                    end
                endcase
            end
            qsed_pkg::PH_HEX1: begin
                if (hx.ok) begin
                    n_pend  = {4'h0, hx.val};
                    n_phase = qsed_pkg::PH_HEX2;
                end else begin
                    pre_emit = 1'b1;
                    pre_data = qsed_pkg::CH_X;
                    use_body = 1'b1;
                end
            end
            qsed_pkg::PH_HEX2: begin
                pre_emit = 1'b1;
                if (hx.ok) begin
                    pre_data = {r_pend[3:0], hx.val};
                    n_phase  = qsed_pkg::PH_BODY;
                end else begin
                    pre_data = r_pend;
                    use_body = 1'b1;
                end
            end
            qsed_pkg::PH_OCT: begin
                pre_emit = 1'b1;
                if (i_byte[7:3] == 5'b00110) begin
                    pre_data = {2'b00, r_pend[2:0], i_byte[2:0]};
                    n_phase  = qsed_pkg::PH_BODY;
                end else begin
                    pre_data = r_pend;
                    use_body = 1'b1;
                end
            end
            qsed_pkg::PH_DONE: begin
                n_phase = qsed_pkg::PH_DONE;
            end
            default: begin
                n_phase = qsed_pkg::PH_DONE;
            end
        endcase

        if (use_body) begin
            n_phase = bs.phase;
        end

        res = '0;
        if (pre_emit) begin
            res.r0.data = pre_data;
            res.r0.kind = pre_kind;
            res.cnt     = 2'd1;
        end
        if (use_body && bs.emit) begin
            if (pre_emit) begin
                res.r1.data = bs.data;
                res.r1.kind = bs.kind;
                res.cnt     = 2'd2;
            end else begin
                res.r0.data = bs.data;
                res.r0.kind = bs.kind;
                res.cnt     = 2'd1;
            end
        end

        // unfinished literal at end of input: error replaces everything
        if (i_last) begin
            if (n_phase != qsed_pkg::PH_DONE) begin
                res         = '0;
                res.cnt     = 2'd1;
                res.r0.kind = qsed_pkg::KIND_ERR;
            end
            n_phase = qsed_pkg::PH_AWAIT;
            n_pend  = 8'h00;
        end

        res.r0.last = (res.cnt == 2'd1);
        res.r1.last = (res.cnt == 2'd2);
        o_res       = res;
    end

endmodule

// ----- rtl/core/qsed_fifo.sv -----
// Result queue taking up to two results per cycle and releasing one per cycle while popped.
module qsed_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  qsed_pkg::t_dec_res i_res,
    input  logic               i_pop,
    output logic               o_room,
    output logic               o_valid,
    output qsed_pkg::t_result  o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX  = CW'(DEPTH - 2);

    qsed_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     wr_1, wr_2;
    logic [1:0]        push_n;
    logic              pop_en;

    assign wr_1   = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
    assign wr_2   = (wr_1 == PTR_LAST) ? '0 : wr_1 + 1'b1;
    assign push_n = i_push ? i_res.cnt : 2'd0;
    assign pop_en = i_pop && (r_cnt != '0);

    always_comb begin
        n_wr = r_wr;
        if (push_n == 2'd1) begin
            n_wr = wr_1;
        end else if (push_n == 2'd2) begin
            n_wr = wr_2;
        end
        n_rd  = pop_en ? ((r_rd == PTR_LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + CW'(push_n) - CW'(pop_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr] <= i_res.r0;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_1] <= i_res.r1;
        end
    end

    assign o_room  = (r_cnt <= ROOM_MAX);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

endmodule

// ----- rtl/core/quoted_string_escape_decoder.sv -----
// Top level of the quoted string escape decoder: input register, decode, result queue.
// A request accepted into the input register is decoded and its results are written
// into the result queue when the queue has room; the output shows the queue head.
// Throughput: one request per cycle while the queue has room; results leave one per
// cycle while the output is ready, so the queue absorbs a request with two results.
// Reset: synchronous, active low; clears the input stage, phase and the result queue.
module quoted_string_escape_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind,
    output logic       o_out_last
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               advance;
    logic               room;
    qsed_pkg::t_dec_res dec_res;
    qsed_pkg::t_result  head;

    assign advance    = r_in_valid && room;
    assign o_in_ready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    qsed_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (dec_res)
    );

    qsed_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_res   (dec_res),
        .i_pop   (i_out_ready),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_out_byte = head.data;
    assign o_out_kind = head.kind;
    assign o_out_last = head.last;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result queue not empty after reset");

    a_status_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind != qsed_pkg::KIND_BYTE) |-> (o_out_byte == 8'h00))
        else $error("completion or error result carries data");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind != qsed_pkg::KIND_BYTE) |-> o_out_last)
        else $error("completion or error result not marked last");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !room) |=> $stable(r_in_byte))
        else $error("held request overwritten while queue full");

endmodule
